// ===== src/ucbt_pkg.sv =====
package ucbt_pkg;

    // defaults for the top level parameters
    localparam int COORD_BITS_DEF = 24;
    localparam int SAMPLES_DEF    = 10;
    localparam int MAX_REPEAT_DEF = 3;

    // curve geometry
    localparam int NUM_AXES  = 3;
    localparam int NUM_TAPS  = 4;
    localparam int WIN_DEPTH = 3;
    localparam logic [1:0] PS_FULL   = 2'(WIN_DEPTH);
    localparam logic [1:0] HEAD_LAST = 2'(WIN_DEPTH - 1);

    // basis weights are unsigned q1.16
    localparam int WEIGHT_BITS = 17;
    localparam int FRAC_BITS   = 16;

    // queue depths
    localparam int JOB_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_COPY,
        FS_WRAP
    } t_front_state;

    // exact numerator of basis j at sample k, denominator is 6*s^3
    function automatic longint bs_num(input int j, input int k, input int s);
        longint kk;
        longint ss;
        longint num;
        kk = longint'(k);
        ss = longint'(s);
        case (j)
            0: num = (ss - kk) * (ss - kk) * (ss - kk);
            1: num = 3 * kk * kk * kk - 6 * kk * kk * ss + 4 * ss * ss * ss;
            2: num = -3 * kk * kk * kk + 3 * kk * kk * ss + 3 * kk * ss * ss + ss * ss * ss;
            default: num = kk * kk * kk;
        endcase
        return num;
    endfunction

endpackage

// ===== src/ucbt_fifo.sv =====
module ucbt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== src/ucbt_front.sv =====
module ucbt_front #(
    parameter int COORD_BITS = ucbt_pkg::COORD_BITS_DEF,
    parameter int MAX_REPEAT = ucbt_pkg::MAX_REPEAT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic [1:0]                   i_multiplicity,
    input  logic                         i_final_point,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic                         i_job_full,
    output logic                         o_job_push,
    output logic [ucbt_pkg::NUM_AXES*ucbt_pkg::NUM_TAPS*COORD_BITS:0] o_job
);
    import ucbt_pkg::*;

    localparam int JOB_W = NUM_AXES * NUM_TAPS * COORD_BITS + 1;

    t_front_state r_state;
    t_front_state n_state;

    logic                         r_closed;
    logic signed [COORD_BITS-1:0] r_pt   [NUM_AXES];
    logic signed [COORD_BITS-1:0] r_win  [NUM_AXES][WIN_DEPTH];
    logic signed [COORD_BITS-1:0] r_head [NUM_AXES][WIN_DEPTH];
    logic [1:0]                   r_rem;
    logic [1:0]                   r_hidx;
    logic [1:0]                   r_ps;
    logic                         r_last;

    logic signed [COORD_BITS-1:0] cur [NUM_AXES];
    logic [1:0]                   rep;
    logic [1:0]                   ps_next;
    logic                         accept;
    logic                         emit;
    logic                         step;
    logic                         last_copy;
    logic                         wrap;
    logic                         fin;
    logic                         end_curve;

    // clamp of the repeat count
    always_comb begin
        if (i_multiplicity == 2'd0) begin
            rep = 2'd1;
        end else if (int'(i_multiplicity) > MAX_REPEAT) begin
            rep = 2'(MAX_REPEAT);
        end else begin
            rep = i_multiplicity;
        end
    end

    // one expanded point per cycle, unless a segment waits on a full job queue
    always_comb begin
        for (int c = 0; c < NUM_AXES; c++) begin
            cur[c] = (r_state == FS_WRAP) ? r_head[c][r_hidx] : r_pt[c];
        end
        accept    = i_push && !o_full;
        emit      = (r_ps == PS_FULL);
        step      = (r_state != FS_IDLE) && !(emit && i_job_full);
        ps_next   = emit ? PS_FULL : r_ps + 1'b1;
        last_copy = (r_state == FS_COPY) && (r_rem == 2'd1);
        wrap      = last_copy && r_last && r_closed && (ps_next == PS_FULL);
        fin       = (last_copy && !wrap) || ((r_state == FS_WRAP) && (r_hidx == HEAD_LAST));
        end_curve = fin && ((r_state == FS_WRAP) || r_last);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: begin
                if (accept) n_state = FS_COPY;
            end
            FS_COPY: begin
                if (step && last_copy) n_state = wrap ? FS_WRAP : FS_IDLE;
            end
            FS_WRAP: begin
                if (step && (r_hidx == HEAD_LAST)) n_state = FS_IDLE;
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        o_full     = (r_state != FS_IDLE) || !i_rst_n;
        o_job_push = step && emit;
        o_job      = '0;
        for (int c = 0; c < NUM_AXES; c++) begin
            for (int j = 0; j < WIN_DEPTH; j++) begin
                o_job[(c * NUM_TAPS + j) * COORD_BITS +: COORD_BITS] = r_win[c][j];
            end
            o_job[(c * NUM_TAPS + WIN_DEPTH) * COORD_BITS +: COORD_BITS] = cur[c];
        end
        o_job[JOB_W-1] = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FS_IDLE;
            r_closed <= 1'b1;
            r_ps     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_closed <= i_cfg_wdata;
            end
            if (step) begin
                r_ps <= end_curve ? 2'd0 : ps_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pt[0] <= i_point_x;
            r_pt[1] <= i_point_y;
            r_pt[2] <= i_point_z;
            r_rem   <= rep;
            r_last  <= i_final_point;
        end else if (step && (r_state == FS_COPY)) begin
            r_rem <= r_rem - 1'b1;
        end
        if (step) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                if (emit) begin
                    for (int j = 0; j < WIN_DEPTH - 1; j++) begin
                        r_win[c][j] <= r_win[c][j+1];
                    end
                    r_win[c][WIN_DEPTH-1] <= cur[c];
                end else begin
                    r_win[c][r_ps]  <= cur[c];
                    r_head[c][r_ps] <= cur[c];
                end
            end
            r_hidx <= (r_state == FS_WRAP) ? r_hidx + 1'b1 : 2'd0;
        end
    end

endmodule

// ===== src/ucbt_back.sv =====
module ucbt_back #(
    parameter int COORD_BITS = ucbt_pkg::COORD_BITS_DEF,
    parameter int SAMPLES    = ucbt_pkg::SAMPLES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_empty,
    input  logic [ucbt_pkg::NUM_AXES*ucbt_pkg::NUM_TAPS*COORD_BITS:0] i_job,
    output logic o_job_pop,
    input  logic [$clog2(ucbt_pkg::OUT_DEPTH+1)-1:0] i_out_count,
    output logic o_out_push,
    output logic [ucbt_pkg::NUM_AXES*COORD_BITS:0] o_out_data
);
    import ucbt_pkg::*;

    localparam int     JOB_W  = NUM_AXES * NUM_TAPS * COORD_BITS + 1;
    localparam int     K_W    = $clog2(SAMPLES);
    localparam int     CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam int     PROD_W = COORD_BITS + WEIGHT_BITS + 1;
    localparam int     SUM_W  = PROD_W + 3;
    localparam longint DEN    = 6 * longint'(SAMPLES) * longint'(SAMPLES) * longint'(SAMPLES);

    localparam logic signed [SUM_W-1:0] ROUND   = SUM_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W - COORD_BITS + 1){1'b1}}, {(COORD_BITS - 1){1'b0}}};

    logic [WEIGHT_BITS-1:0] w_tab [SAMPLES][NUM_TAPS];

    // rounded basis weights, fixed at elaboration
    for (genvar gk = 0; gk < SAMPLES; gk++) begin : g_k
        for (genvar gj = 0; gj < NUM_TAPS; gj++) begin : g_j
            localparam longint NUM = bs_num(gj, gk, SAMPLES);
            localparam longint WGT = (NUM * 65536 + DEN / 2) / DEN;
            assign w_tab[gk][gj] = WEIGHT_BITS'(WGT);
        end
    end

    logic [K_W-1:0]           r_k;
    logic                     r_v1;
    logic                     r_end1;
    logic signed [PROD_W-1:0] r_prod [NUM_AXES][NUM_TAPS];

    logic signed [COORD_BITS-1:0] pt  [NUM_AXES][NUM_TAPS];
    logic signed [SUM_W-1:0]      acc [NUM_AXES];
    logic signed [SUM_W-1:0]      res [NUM_AXES];
    logic signed [COORD_BITS-1:0] sat [NUM_AXES];
    logic                         issue;
    logic                         last_k;

    always_comb begin
        for (int c = 0; c < NUM_AXES; c++) begin
            for (int j = 0; j < NUM_TAPS; j++) begin
                pt[c][j] = i_job[(c * NUM_TAPS + j) * COORD_BITS +: COORD_BITS];
            end
        end
    end

    // issue a sample only when the result queue has room for it
    assign issue = !i_job_empty &&
        ((CNT_W + 1)'(i_out_count) + (CNT_W + 1)'(r_v1) < (CNT_W + 1)'(OUT_DEPTH));
    assign last_k    = (r_k == K_W'(SAMPLES - 1));
    assign o_job_pop = issue && last_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= '0;
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= issue;
            if (issue) begin
                r_k <= last_k ? '0 : r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_end1 <= i_job[JOB_W-1] && last_k;
            for (int c = 0; c < NUM_AXES; c++) begin
                for (int j = 0; j < NUM_TAPS; j++) begin
                    r_prod[c][j] <= $signed(pt[c][j]) * $signed({1'b0, w_tab[r_k][j]});
                end
            end
        end
    end

    // sum, round half up, saturate
    always_comb begin
        for (int c = 0; c < NUM_AXES; c++) begin
            acc[c] = SUM_W'(r_prod[c][0]) + SUM_W'(r_prod[c][1]) +
                     SUM_W'(r_prod[c][2]) + SUM_W'(r_prod[c][3]) + ROUND;
            res[c] = acc[c] >>> FRAC_BITS;
            if (res[c] > SAT_MAX) begin
                sat[c] = SAT_MAX[COORD_BITS-1:0];
            end else if (res[c] < SAT_MIN) begin
                sat[c] = SAT_MIN[COORD_BITS-1:0];
            end else begin
                sat[c] = res[c][COORD_BITS-1:0];
            end
        end
    end

    assign o_out_push = r_v1;
    assign o_out_data = {r_end1, sat[2], sat[1], sat[0]};

endmodule

// ===== src/uniform_cubic_bspline_tessellator_top.sv =====
// uniform cubic b-spline tessellator. control points (signed q8.16 x, y, z) go in through a
// push/full queue port, each with a repeat count of 1 to 3 (0 counts as 1) and a flag that
// marks the last point of a curve. every point enters the control stream as many times as
// its repeat count; the first three expanded points of a curve only fill the window, and
// each further one gives SAMPLES_PER_SEGMENT curve samples at t = k/SAMPLES_PER_SEGMENT,
// rounded half up and saturated to the coordinate range. run_end marks the last sample of
// a request; a request that yields no sample gives nothing on the output side. with
// closed_loop set (the reset value) the last point of a curve of three or more expanded
// points also feeds the first three expanded points again, which closes the loop; a shorter
// curve is never wrapped. after the last point a new curve starts. closed_loop is written
// through i_cfg_we/i_cfg_wdata; the user must write it only while the block is idle, since
// the block itself does not enforce this. the front stage accepts a request and stays full
// until it has passed on all of that request's expanded points, stalling while the job
// queue is full; the evaluation stage has one multiply-accumulate datapath that gives one
// sample per cycle while a job waits and the result queue has room. a two-entry job queue
// between the stages and a four-entry result queue let input and output stall
// independently. a result reaches the ports through the front's point registers, the job
// queue, the product registers and the result queue.
module uniform_cubic_bspline_tessellator_top #(
    parameter int COORD_BITS          = ucbt_pkg::COORD_BITS_DEF,
    parameter int SAMPLES_PER_SEGMENT = ucbt_pkg::SAMPLES_DEF,
    parameter int MAX_REPEAT          = ucbt_pkg::MAX_REPEAT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    // control point requests
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic [1:0]                   i_multiplicity,
    input  logic                         i_final_point,
    input  logic                         push,
    output logic                         full,
    // curve sample requests
    output logic signed [COORD_BITS-1:0] o_curve_x,
    output logic signed [COORD_BITS-1:0] o_curve_y,
    output logic signed [COORD_BITS-1:0] o_curve_z,
    output logic                         o_run_end,
    output logic                         empty,
    input  logic                         pop
);
    import ucbt_pkg::*;

    localparam int JOB_W = NUM_AXES * NUM_TAPS * COORD_BITS + 1;
    localparam int OUT_W = NUM_AXES * COORD_BITS + 1;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    // front to job queue
    logic             job_push;
    logic [JOB_W-1:0] job_in;
    logic             job_full;
    // job queue to back
    logic [JOB_W-1:0] job_out;
    logic             job_empty;
    logic             job_pop;
    // back to result queue
    logic             out_push;
    logic [OUT_W-1:0] out_in;
    logic [OUT_W-1:0] out_data;
    logic [CNT_W-1:0] out_count;

    // window, head points, repeat expansion and loop closing
    ucbt_front #(
        .COORD_BITS (COORD_BITS),
        .MAX_REPEAT (MAX_REPEAT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_multiplicity (i_multiplicity),
        .i_final_point  (i_final_point),
        .i_push         (push),
        .o_full         (full),
        .i_job_full     (job_full),
        .o_job_push     (job_push),
        .o_job          (job_in)
    );

    // four-point segments waiting for evaluation
    ucbt_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty),
        .o_count ()
    );

    // one sample per cycle while a job waits and the result queue has room: weight multiply, then sum and saturate
    ucbt_back #(
        .COORD_BITS (COORD_BITS),
        .SAMPLES    (SAMPLES_PER_SEGMENT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_data  (out_in)
    );

    // finished samples, oldest on the ports
    ucbt_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .o_full  (),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_curve_x = out_data[COORD_BITS-1:0];
    assign o_curve_y = out_data[2*COORD_BITS-1:COORD_BITS];
    assign o_curve_z = out_data[3*COORD_BITS-1:2*COORD_BITS];
    assign o_run_end = out_data[OUT_W-1];

endmodule

// ===== src/ucbt_checker.sv =====
module ucbt_checker #(
    parameter int COORD_BITS = ucbt_pkg::COORD_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         push,
    input logic                         full,
    input logic signed [COORD_BITS-1:0] o_curve_x,
    input logic signed [COORD_BITS-1:0] o_curve_y,
    input logic signed [COORD_BITS-1:0] o_curve_z,
    input logic                         o_run_end,
    input logic                         empty,
    input logic                         pop
);

    // no samples left over from before reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // input side open once reset is released
    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n ##1 i_rst_n |-> !full)
        else $error("input full right after reset");

    // an accepted request leaves the front busy in the cycle after
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full)
        else $error("input accepted twice in consecutive cycles");

    // a waiting sample holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_curve_x) && $stable(o_curve_y)
            && $stable(o_curve_z) && $stable(o_run_end)))
        else $error("waiting sample changed before pop");

endmodule

bind uniform_cubic_bspline_tessellator_top ucbt_checker #(
    .COORD_BITS (COORD_BITS)
) u_ucbt_checker (.*);

// ===== test/uniform_cubic_bspline_tessellator_top_tb.sv =====
module uniform_cubic_bspline_tessellator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB  = ucbt_pkg::COORD_BITS_DEF;
    localparam int SEG = ucbt_pkg::SAMPLES_DEF;

    localparam logic LOOP_OPEN   = 1'b0;
    localparam logic LOOP_CLOSED = 1'b1;

    localparam longint SAT_HI = (longint'(1) << (CB - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    // receiver stops for a long stretch after this many samples
    localparam int HOLD_AT     = 600;
    localparam int HOLD_CYCLES = 400;

    typedef logic signed [CB-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    typedef struct packed {
        t_point     pt;
        logic [1:0] mult;
        logic       last;
    } t_cp_request;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   run_end;
    } t_sample;

    localparam t_coord C_MAX = t_coord'(SAT_HI);
    localparam t_coord C_MIN = t_coord'(SAT_LO);
    localparam t_coord C_ONE = t_coord'(65536);

    // dut ports
    logic   i_clk          = 1'b0;
    logic   i_rst_n        = 1'b0;
    logic   i_cfg_we       = 1'b0;
    logic   i_cfg_wdata    = 1'b0;
    t_coord i_point_x      = '0;
    t_coord i_point_y      = '0;
    t_coord i_point_z      = '0;
    logic [1:0] i_multiplicity = 2'd1;
    logic   i_final_point  = 1'b0;
    logic   push           = 1'b0;
    logic   full;
    t_coord o_curve_x;
    t_coord o_curve_y;
    t_coord o_curve_z;
    logic   o_run_end;
    logic   empty;
    logic   pop            = 1'b0;

    // stimulus and prediction state
    t_cp_request points_to_send[$];
    t_cp_request drv_item = '0;
    t_sample     samples_due[$];
    int          items_queued = 0;
    int          items_taken  = 0;
    int          samples_seen = 0;
    int          fail_count   = 0;
    bit          quiet_tail   = 1'b0;

    // predictor copy of the curve state
    t_point      win[3];
    t_point      head[3];
    int          held = 0;
    logic        loop_closed = LOOP_CLOSED;

    uniform_cubic_bspline_tessellator_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_multiplicity (i_multiplicity),
        .i_final_point  (i_final_point),
        .push           (push),
        .full           (full),
        .o_curve_x      (o_curve_x),
        .o_curve_y      (o_curve_y),
        .o_curve_z      (o_curve_z),
        .o_run_end      (o_run_end),
        .empty          (empty),
        .pop            (pop)
    );

    always #5 i_clk = ~i_clk;

    // q0.16 basis weight j at sample k, rounded half up
    function automatic longint basis_weight(input int j, input int k);
        longint s;
        longint t;
        longint cube;
        longint num;
        s = longint'(SEG);
        t = longint'(k);
        cube = s * s * s;
        case (j)
            0: num = (s - t) * (s - t) * (s - t);
            1: num = 3 * t * t * t - 6 * t * t * s + 4 * cube;
            2: num = -3 * t * t * t + 3 * t * t * s + 3 * t * s * s + cube;
            default: num = t * t * t;
        endcase
        return (num * 65536 + 3 * cube) / (6 * cube);
    endfunction

    // one axis of one sample: weighted sum, round half up, saturate
    function automatic t_coord curve_value(input t_coord a, input t_coord b,
                                           input t_coord c, input t_coord d, input int k);
        longint acc;
        acc = basis_weight(0, k) * longint'(a) + basis_weight(1, k) * longint'(b)
            + basis_weight(2, k) * longint'(c) + basis_weight(3, k) * longint'(d);
        acc = (acc + 32768) >>> 16;
        if (acc > SAT_HI) acc = SAT_HI;
        if (acc < SAT_LO) acc = SAT_LO;
        return t_coord'(acc);
    endfunction

    // one expanded control point: fills the window or closes a segment
    function automatic void feed_point(input t_point p);
        t_sample s;
        if (held >= 3) begin
            for (int k = 0; k < SEG; k++) begin
                s.x = curve_value(win[0].x, win[1].x, win[2].x, p.x, k);
                s.y = curve_value(win[0].y, win[1].y, win[2].y, p.y, k);
                s.z = curve_value(win[0].z, win[1].z, win[2].z, p.z, k);
                s.run_end = 1'b0;
                samples_due.push_back(s);
            end
            win[0] = win[1];
            win[1] = win[2];
            win[2] = p;
        end else begin
            head[held] = p;
            win[held] = p;
            held++;
        end
    endfunction

    // expected samples of one accepted control point request
    function automatic void predict_curve_samples(input t_cp_request r);
        int      copies;
        int      before_n;
        t_point  wrap[3];
        t_sample tail;
        copies = (r.mult == 2'd0) ? 1 : int'(r.mult);
        before_n = samples_due.size();
        repeat (copies) feed_point(r.pt);
        if (r.last) begin
            // wrap only a curve that already holds three expanded points
            if (loop_closed == LOOP_CLOSED && held >= 3) begin
                wrap = head;
                for (int i = 0; i < 3; i++) feed_point(wrap[i]);
            end
            for (int i = 0; i < 3; i++) begin
                win[i] = '0;
                head[i] = '0;
            end
            held = 0;
        end
        if (samples_due.size() > before_n) begin
            tail = samples_due.pop_back();
            tail.run_end = 1'b1;
            samples_due.push_back(tail);
        end
    endfunction

    function automatic t_coord rand_coord();
        int v;
        case ($urandom_range(0, 9))
            0: return C_MAX;
            1: return C_MIN;
            2: return C_MAX - t_coord'($urandom_range(0, 255));
            3: return C_MIN + t_coord'($urandom_range(0, 255));
            4, 5: begin
                v = $urandom_range(0, 1 << 19);
                return t_coord'(v - (1 << 18));
            end
            default: return t_coord'($urandom);
        endcase
    endfunction

    task automatic add_point(input t_coord x, input t_coord y, input t_coord z,
                             input logic [1:0] m, input logic f);
        t_cp_request r;
        r.pt.x = x;
        r.pt.y = y;
        r.pt.z = z;
        r.mult = m;
        r.last = f;
        points_to_send.push_back(r);
        items_queued++;
    endtask

    // mostly whole curves with random content, some one- and two-point curves
    task automatic add_random_curves(input int n_items);
        int added;
        int len;
        added = 0;
        while (added < n_items) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            for (int i = 0; i < len && added < n_items; i++) begin
                add_point(rand_coord(), rand_coord(), rand_coord(),
                          2'($urandom_range(0, 3)), i == len - 1);
                added++;
            end
        end
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || samples_due.size() != 0) @(posedge i_clk);
    endtask

    // register write only with nothing in flight
    task automatic set_loop_mode(input logic mode);
        wait_drained();
        // a point that gives no sample may still be moving through the front stage
        repeat (20) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        loop_closed = mode;
    endtask

    // sender: holds each request until it is taken, idles in random bursts
    int send_gap       = 0;
    int send_mode_left = 0;
    int send_odds      = 0;

    always @(posedge i_clk) begin : sender
        bit live;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            live = push;
            if (push && !full) begin
                predict_curve_samples(drv_item);
                items_taken++;
                live = 1'b0;
            end
            if (send_mode_left == 0) begin
                send_mode_left = $urandom_range(40, 200);
                case ($urandom_range(0, 2))
                    0: send_odds = 0;
                    1: send_odds = 4;
                    default: send_odds = 12;
                endcase
            end else begin
                send_mode_left--;
            end
            if (!live) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (points_to_send.size() > 0) begin
                    if (!quiet_tail && send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
                        send_gap = $urandom_range(1, 17) - 1;
                    end else begin
                        drv_item = points_to_send.pop_front();
                        live = 1'b1;
                    end
                end
            end
            push           <= live;
            i_point_x      <= drv_item.pt.x;
            i_point_y      <= drv_item.pt.y;
            i_point_z      <= drv_item.pt.z;
            i_multiplicity <= drv_item.mult;
            i_final_point  <= drv_item.last;
        end
    end

    // receiver: checks every taken sample against the oldest one due
    int recv_gap       = 0;
    int recv_mode_left = 0;
    int recv_odds      = 0;
    int hold_left      = 0;

    always @(posedge i_clk) begin : receiver
        t_sample got;
        t_sample want;
        bit      take;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got.x = o_curve_x;
                got.y = o_curve_y;
                got.z = o_curve_z;
                got.run_end = o_run_end;
                if (samples_due.size() == 0) begin
                    $error("sample with none due: x %0d y %0d z %0d run_end %0d",
                           got.x, got.y, got.z, got.run_end);
                    fail_count++;
                end else begin
                    want = samples_due.pop_front();
                    if (got.x !== want.x) begin
                        $error("curve_x: expected %0d, got %0d", want.x, got.x);
                        fail_count++;
                    end
                    if (got.y !== want.y) begin
                        $error("curve_y: expected %0d, got %0d", want.y, got.y);
                        fail_count++;
                    end
                    if (got.z !== want.z) begin
                        $error("curve_z: expected %0d, got %0d", want.z, got.z);
                        fail_count++;
                    end
                    if (got.run_end !== want.run_end) begin
                        $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
                        fail_count++;
                    end
                end
                samples_seen++;
                // long stall so the block backs up and raises full
                if (samples_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (recv_mode_left == 0) begin
                recv_mode_left = $urandom_range(40, 200);
                case ($urandom_range(0, 2))
                    0: recv_odds = 0;
                    1: recv_odds = 4;
                    default: recv_odds = 12;
                endcase
            end else begin
                recv_mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                take = 1'b0;
            end else if (!quiet_tail && recv_odds != 0 && $urandom_range(1, recv_odds) == 1) begin
                recv_gap = $urandom_range(1, 17) - 1;
                take = 1'b0;
            end else begin
                take = 1'b1;
            end
            pop <= take;
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // closed loop from reset
        // lone point: short curve, nothing out
        add_point(C_ONE, t_coord'(2 * 65536), t_coord'(3 * 65536), 2'd1, 1'b1);
        // zero repeat counts as one, exactly three expanded points then wrap
        add_point(C_MAX, C_MIN, '0, 2'd0, 1'b0);
        add_point(t_coord'(-1), t_coord'(1), t_coord'(12345), 2'd2, 1'b1);
        // two expanded points: too short to wrap
        add_point(t_coord'(-65536), C_ONE, t_coord'(7), 2'd2, 1'b1);
        // all at the top of the range, most samples per request, saturation high
        add_point(C_MAX, C_MAX, C_MAX, 2'd3, 1'b0);
        add_point(C_MAX, C_MAX, C_MAX, 2'd3, 1'b1);
        // all at the bottom, triple point wraps onto itself
        add_point(C_MIN, C_MIN, C_MIN, 2'd3, 1'b1);
        // swinging between extremes
        add_point(C_MAX, C_MIN, C_MAX, 2'd1, 1'b0);
        add_point(C_MIN, C_MAX, C_MIN, 2'd1, 1'b0);
        add_point(C_MAX, C_MIN, C_MAX, 2'd1, 1'b0);
        add_point(C_MIN, C_MAX, C_MIN, 2'd1, 1'b0);
        add_point(C_MAX, C_MIN, '0, 2'd1, 1'b1);

        // open curves: no wrap on the last point
        set_loop_mode(LOOP_OPEN);
        add_point(C_ONE, '0, t_coord'(-65536), 2'd1, 1'b0);
        add_point(t_coord'(5 * 65536), C_MAX, t_coord'(32768), 2'd2, 1'b0);
        add_point(C_MIN, t_coord'(-32768), C_ONE, 2'd3, 1'b0);
        add_point(t_coord'(123456), t_coord'(-654321), C_MAX, 2'd0, 1'b0);
        add_point(t_coord'(-7), t_coord'(32767), C_MIN, 2'd1, 1'b1);
        // three expanded points, open: nothing out
        add_point(C_ONE, C_ONE, C_ONE, 2'd3, 1'b1);
        add_random_curves(160);

        set_loop_mode(LOOP_CLOSED);
        add_random_curves(160);

        set_loop_mode(LOOP_OPEN);
        add_random_curves(80);

        // last stretch runs without idling on either side
        set_loop_mode(LOOP_CLOSED);
        quiet_tail = 1'b1;
        add_random_curves(80);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ucbt_pkg.sv
src/ucbt_fifo.sv
src/ucbt_front.sv
src/ucbt_back.sv
src/uniform_cubic_bspline_tessellator_top.sv
src/ucbt_checker.sv
test/uniform_cubic_bspline_tessellator_top_tb.sv
